### rtl/gha_pkg.sv
// shared types and constants for the generational handle allocator
// no dependencies; imported by every module of the block
`default_nettype none

package gha_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int GEN_BITS   = 16;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = IDX_W + 1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CHECK   = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOT_LIVE = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      op_type        req_type;
      logic [6:0]    handle_slot;
      logic [15:0]   handle_gen;
   } req_item_type;

   typedef struct packed {
      status_type    status;
      logic [6:0]    out_slot;
      logic [15:0]   out_gen;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WAIT_QUEUE,
      ST_FINISH
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_req;
      logic rd_queue;
      logic rd_gen_req;
      logic rd_gen_queue;
      logic commit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   queue_nonempty;
      logic   slot_ok;
      logic   out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/generational_handle_allocator_core.sv
// top level of the generational handle allocator
// depends on gha_pkg, gha_ctrl and gha_datapath
//
// Usage: a request on req_* (valid/ready) carries an operation code
// (allocate, release, check, clear all) and a handle (slot, generation);
// each request produces exactly one response on rsp_* (valid/ready) with a
// status and, for a successful allocation, the new handle. Slot 0 is null.
// Requests are handled one at a time by a small sequencer around two
// single-port memories (per-slot generations and the free-slot queue).
// Flow: the request is registered, the memory read is issued in the
// dispatch state, and the result is committed to the response register;
// a reuse allocation adds a queue-wait state, since the queue read and
// the generation read follow one another. A new request is accepted
// after the commit; a pending response sits in an output register, so
// the next request is accepted while it waits; a stalled receiver only
// holds back the result of that following request.
// Reset: synchronous, active high; empties the queue and closes all slots,
// memory contents are left as they are and are never read before written.
`default_nettype none

module generational_handle_allocator_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  gha_pkg::req_item_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output gha_pkg::rsp_item_type  rsp_data
);
   import gha_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   gha_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/gha_ctrl.sv
// sequencing state machine of the handle allocator
// depends on gha_pkg; drives the command struct of gha_datapath
`default_nettype none

module gha_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  gha_pkg::dp_status_type  dp_status,
   output gha_pkg::ctrl_cmd_type   cmd
);
   import gha_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (dp_status.op) inside
               OP_ALLOC: begin
                  // reuse a released slot first
                  if (dp_status.queue_nonempty) begin
                     cmd.rd_queue = 1'b1;
                     state_in     = ST_WAIT_QUEUE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               OP_RELEASE, OP_CHECK: begin
                  cmd.rd_gen_req = dp_status.slot_ok;
                  state_in       = ST_FINISH;
               end
               OP_CLEAR: begin
                  state_in = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_WAIT_QUEUE: begin
            cmd.rd_gen_queue = 1'b1;
            state_in         = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register can take the result
            if (dp_status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/gha_datapath.sv
// generation memory, free-slot queue, counters and response register
// depends on gha_pkg; controlled by gha_ctrl through the command struct
`default_nettype none

module gha_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  gha_pkg::req_item_type   req_data,
   input  gha_pkg::ctrl_cmd_type   cmd,
   output gha_pkg::dp_status_type  dp_status,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output gha_pkg::rsp_item_type   rsp_data
);
   import gha_pkg::*;

   logic [GEN_BITS-1:0] gen_mem [SLOT_COUNT];
   logic [IDX_W-1:0]    queue_mem [SLOT_COUNT];

   req_item_type        req_ff;
   logic [GEN_BITS-1:0] gen_rd_ff;
   logic [IDX_W-1:0]    queue_rd_ff;

   logic [CNT_W-1:0]    opened_ff,  opened_in;
   logic [IDX_W-1:0]    head_ff,    head_in;
   logic [IDX_W-1:0]    tail_ff,    tail_in;
   logic [CNT_W-1:0]    count_ff,   count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff,     rsp_in;

   logic                slot_ok;
   logic [IDX_W-1:0]    slot_idx;
   logic [6:0]          slot_minus_one;
   logic [IDX_W-1:0]    gen_rd_addr;
   logic                gen_live;

   logic                gen_we;
   logic [IDX_W-1:0]    gen_wr_addr;
   logic [GEN_BITS-1:0] gen_wr_data;
   logic                queue_we;

   // slot field and fill counters share one width
   assign slot_ok        = (req_ff.handle_slot != 7'd0) && (req_ff.handle_slot <= opened_ff);
   assign slot_minus_one = req_ff.handle_slot - 7'd1;
   assign slot_idx       = slot_minus_one[IDX_W-1:0];
   assign gen_rd_addr    = cmd.rd_gen_queue ? queue_rd_ff : slot_idx;
   assign gen_live       = slot_ok && (gen_rd_ff == req_ff.handle_gen);

   assign dp_status.op             = req_ff.req_type;
   assign dp_status.queue_nonempty = (count_ff != '0);
   assign dp_status.slot_ok        = slot_ok;
   assign dp_status.out_free       = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_ff <= req_data;
      end
      if (cmd.rd_queue) begin
         queue_rd_ff <= queue_mem[head_ff];
      end
      if (cmd.rd_gen_req || cmd.rd_gen_queue) begin
         gen_rd_ff <= gen_mem[gen_rd_addr];
      end
      if (gen_we) begin
         gen_mem[gen_wr_addr] <= gen_wr_data;
      end
      if (queue_we) begin
         queue_mem[tail_ff] <= slot_idx;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opened_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         opened_ff    <= opened_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      opened_in    = opened_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      gen_we       = 1'b0;
      gen_wr_addr  = slot_idx;
      gen_wr_data  = gen_rd_ff + GEN_BITS'(1);
      queue_we     = 1'b0;

      if (cmd.commit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = STATUS_OK;
         rsp_in.out_slot = 7'd0;
         rsp_in.out_gen  = 16'd0;
         unique case (req_ff.req_type)
            OP_ALLOC: begin
               if (count_ff != '0) begin
                  rsp_in.out_slot = 7'(queue_rd_ff) + 7'd1;
                  rsp_in.out_gen  = gen_rd_ff;
                  head_in  = (head_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : head_ff + IDX_W'(1);
                  count_in = count_ff - CNT_W'(1);
               end else if (opened_ff < CNT_W'(SLOT_COUNT)) begin
                  // open a fresh slot at generation one
                  gen_we          = 1'b1;
                  gen_wr_addr     = opened_ff[IDX_W-1:0];
                  gen_wr_data     = GEN_BITS'(1);
                  opened_in       = opened_ff + CNT_W'(1);
                  rsp_in.out_slot = 7'(opened_ff) + 7'd1;
                  rsp_in.out_gen  = 16'd1;
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
            end
            OP_RELEASE: begin
               if (gen_live) begin
                  gen_we = 1'b1;
                  // a full queue only follows a repeated release; skip the push
                  if (count_ff < CNT_W'(SLOT_COUNT)) begin
                     queue_we = 1'b1;
                     tail_in  = (tail_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : tail_ff + IDX_W'(1);
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  rsp_in.status = STATUS_NOT_LIVE;
               end
            end
            OP_CHECK: begin
               rsp_in.status = gen_live ? STATUS_OK : STATUS_NOT_LIVE;
            end
            OP_CLEAR: begin
               opened_in = '0;
               head_in   = '0;
               tail_in   = '0;
               count_in  = '0;
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
